@@ rtl/core/rpn_pkg.sv @@
// Shared constants for the RPN stack evaluator: defaults, token codes and status codes.
`timescale 1ns / 1ps

package rpn_pkg;

    localparam int RPN_STACK_DEPTH   = 16;
    localparam int RPN_FRACTION_BITS = 16;

    localparam int CMD_W = 3;
    localparam int ST_W  = 3;
    localparam int NUM_W = 32;

    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_END  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [ST_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [ST_W-1:0] ST_INVALID   = 3'd4;
    localparam logic [ST_W-1:0] ST_TOOFEW    = 3'd5;
    localparam logic [ST_W-1:0] ST_TOOMANY   = 3'd6;

endpackage

@@ rtl/core/rpn_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/rpn_stack_evaluator.sv @@
// RPN evaluator over pre-split tokens: push/add/sub/end/error results are registered in S_EXEC, multiply
// in S_MUL, divide via setup, range check (S_DIVCHK), 33 quotient bits (S_DIV) and sign fix-up (S_DIVFIN).
// One item at a time: the next item is taken only once the result is registered and the state is idle,
// and only while the output register is empty or its result is being taken (m_tready).
// Stack entries live in a RAM (one read, one write port); the top entry is also kept in a register.
// Reset (aresetn low, synchronous) empties the stack and clears the error latch; RAM is not cleared.
`timescale 1ns / 1ps

module rpn_stack_evaluator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH   = RPN_STACK_DEPTH,
    parameter int FRACTION_BITS = RPN_FRACTION_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] status, [34:3] top_value, [39:35] zero
    output logic        m_tlast    // done_res
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int QB    = 33;                       // quotient bits developed by the divider
    localparam int DVW   = QB + FRACTION_BITS + 1;
    localparam int CNTW  = $clog2(QB + 1);

    localparam logic signed [63:0] MAX64 = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] MIN64 = -64'sh0000_0000_8000_0000;
    localparam logic [NUM_W-1:0] MAX32 = 32'h7FFF_FFFF;
    localparam logic [NUM_W-1:0] MIN32 = 32'h8000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIVCHK,
        S_DIV,
        S_DIVFIN
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [ST_W-1:0]   err_reg, err_next;
    logic [NUM_W-1:0]  top_reg, top_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [NUM_W-1:0]  opnd_reg, opnd_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [DVW-1:0]    dvd_reg, dvd_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  bmag_reg, bmag_next;
    logic              neg_reg, neg_next;
    logic [QB-1:0]     q_reg, q_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [ST_W-1:0]   m_status_reg, m_status_next;
    logic [NUM_W-1:0]  m_value_reg, m_value_next;
    logic              m_last_reg, m_last_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [NUM_W-1:0]  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [NUM_W-1:0]  ram_rdata;

    logic [CW-1:0]     count_m2;
    logic [NUM_W-1:0]  top_or_zero;
    logic              accept;

    // Writes land before the next item's read is issued, so no forwarding.
    rpn_ram #(
        .WIDTH (NUM_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign count_m2    = CW'(count_reg - CW'(2));
    assign ram_raddr   = count_m2[AW-1:0];   // entry below the top, read during accept
    assign top_or_zero = (count_reg == '0) ? '0 : top_reg;

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_value_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

    always_comb begin
        logic              out_fire;
        logic [ST_W-1:0]   out_status;
        logic [NUM_W-1:0]  out_value;
        logic              out_last;
        logic              op_done;
        logic [NUM_W-1:0]  op_val;
        logic [32:0]       sum33;
        logic signed [63:0] sh;
        logic [NUM_W-1:0]  amag;
        logic [NUM_W-1:0]  rzero;
        logic [32:0]       rem_sh;
        logic [32:0]       rem_sub;

        state_next    = state_reg;
        count_next    = count_reg;
        err_next      = err_reg;
        top_next      = top_reg;
        cmd_next      = cmd_reg;
        opnd_next     = opnd_reg;
        prod_next     = prod_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        bmag_next     = bmag_reg;
        neg_next      = neg_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_last_next   = m_last_reg;

        ram_we     = 1'b0;
        ram_waddr  = count_reg[AW-1:0];
        ram_wdata  = opnd_reg;

        out_fire   = 1'b0;
        out_status = err_reg;
        out_value  = top_or_zero;
        out_last   = 1'b0;
        op_done    = 1'b0;
        op_val     = '0;
        sum33      = '0;
        sh         = '0;
        amag       = '0;
        rzero      = '0;
        rem_sh     = '0;
        rem_sub    = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next   = s_tuser;
                    opnd_next  = s_tdata;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (cmd_reg == CMD_END) begin
                    out_fire = 1'b1;
                    out_last = 1'b1;
                    out_value = '0;
                    if (err_reg != ST_OK) begin
                        out_status = err_reg;
                    end else if (count_reg == '0) begin
                        out_status = ST_TOOFEW;
                    end else if (count_reg > CW'(1)) begin
                        out_status = ST_TOOMANY;
                    end else begin
                        out_status = ST_OK;
                        out_value  = top_reg;
                    end
                    count_next = '0;
                    err_next   = ST_OK;
                end else if (err_reg != ST_OK) begin
                    out_fire = 1'b1;   // latched error: token has no effect
                end else begin
                    case (cmd_reg)
                        CMD_PUSH: begin
                            out_fire = 1'b1;
                            if (count_reg == CW'(STACK_DEPTH)) begin
                                err_next   = ST_OVERFLOW;
                                out_status = ST_OVERFLOW;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = opnd_reg;
                                top_next   = opnd_reg;
                                count_next = CW'(count_reg + CW'(1));
                                out_status = ST_OK;
                                out_value  = opnd_reg;
                            end
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                            if (count_reg < CW'(2)) begin
                                out_fire   = 1'b1;
                                err_next   = ST_UNDERFLOW;
                                out_status = ST_UNDERFLOW;
                            end else if (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB) begin
                                if (cmd_reg == CMD_ADD) begin
                                    sum33 = {ram_rdata[31], ram_rdata} + {top_reg[31], top_reg};
                                end else begin
                                    sum33 = {ram_rdata[31], ram_rdata} - {top_reg[31], top_reg};
                                end
                                op_done = 1'b1;
                                if (sum33[32] != sum33[31]) begin
                                    op_val = sum33[32] ? MIN32 : MAX32;
                                end else begin
                                    op_val = sum33[31:0];
                                end
                            end else if (cmd_reg == CMD_MUL) begin
                                prod_next  = $signed(ram_rdata) * $signed(top_reg);
                                state_next = S_MUL;
                            end else if (top_reg == '0) begin
                                out_fire   = 1'b1;
                                err_next   = ST_DIVZERO;
                                out_status = ST_DIVZERO;
                            end else begin
                                amag       = ram_rdata[31] ? NUM_W'(-ram_rdata) : ram_rdata;
                                bmag_next  = top_reg[31] ? NUM_W'(-top_reg) : top_reg;
                                neg_next   = ram_rdata[31] ^ top_reg[31];
                                dvd_next   = DVW'(amag) << FRACTION_BITS;
                                state_next = S_DIVCHK;
                            end
                        end
                        default: begin
                            out_fire   = 1'b1;
                            err_next   = ST_INVALID;
                            out_status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_MUL: begin
                sh      = prod_reg >>> FRACTION_BITS;   // floor toward minus infinity
                op_done = 1'b1;
                if (sh > MAX64) begin
                    op_val = MAX32;
                end else if (sh < MIN64) begin
                    op_val = MIN32;
                end else begin
                    op_val = sh[31:0];
                end
            end
            S_DIVCHK: begin
                // high part of the dividend at or above the divisor: quotient needs > 33 bits
                rzero = NUM_W'(dvd_reg[DVW-1:QB]);
                if (rzero >= bmag_reg) begin
                    op_done = 1'b1;
                    op_val  = neg_reg ? MIN32 : MAX32;
                end else begin
                    rem_next   = rzero;
                    q_next     = '0;
                    cnt_next   = CNTW'(QB);
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                rem_sh  = {rem_reg, dvd_reg[QB-1]};
                rem_sub = rem_sh - {1'b0, bmag_reg};
                dvd_next = dvd_reg << 1;
                if (rem_sh >= {1'b0, bmag_reg}) begin
                    rem_next = rem_sub[31:0];
                    q_next   = {q_reg[QB-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[31:0];
                    q_next   = {q_reg[QB-2:0], 1'b0};
                end
                cnt_next = CNTW'(cnt_reg - CNTW'(1));
                if (cnt_reg == CNTW'(1)) begin
                    state_next = S_DIVFIN;
                end
            end
            S_DIVFIN: begin
                op_done = 1'b1;
                if (!neg_reg && (q_reg[32] || q_reg[31])) begin
                    op_val = MAX32;
                end else if (neg_reg && (q_reg[32] || (q_reg[31] && |q_reg[30:0]))) begin
                    op_val = MIN32;
                end else if (neg_reg) begin
                    op_val = NUM_W'(-q_reg);
                end else begin
                    op_val = q_reg[31:0];
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // binary op retires: replace the two top entries with the result
        if (op_done) begin
            ram_we     = 1'b1;
            ram_waddr  = count_m2[AW-1:0];
            ram_wdata  = op_val;
            top_next   = op_val;
            count_next = CW'(count_reg - CW'(1));
            out_fire   = 1'b1;
            out_status = ST_OK;
            out_value  = op_val;
        end

        if (out_fire) begin
            m_tvalid_next = 1'b1;
            m_status_next = out_status;
            m_value_next  = out_value;
            m_last_next   = out_last;
            state_next    = S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg      <= top_next;
        cmd_reg      <= cmd_next;
        opnd_reg     <= opnd_next;
        prod_reg     <= prod_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        bmag_reg     <= bmag_next;
        neg_reg      <= neg_next;
        q_reg        <= q_next;
        cnt_reg      <= cnt_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_last_reg   <= m_last_next;
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            err_reg      <= ST_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            err_reg      <= err_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (count_reg == '0 && err_reg == ST_OK))
        else $error("end item left stack or error latch set");

    a_status_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[2:0] == err_reg))
        else $error("token status differs from error latch");

    a_end_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast && m_tdata[2:0] != ST_OK) |-> (m_tdata[34:3] == '0))
        else $error("failed end item carries nonzero value");
`endif

endmodule

@@ tb/sv/rpn_result_checker.sv @@
// Result checker for the RPN evaluator: predicts each token's result and compares.
`timescale 1ns / 1ps

module rpn_result_checker
    import rpn_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [NUM_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]  s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [39:0]       m_tdata,
    input  logic              m_tlast,
    output int                fail_count,
    output int                pending
);

    localparam longint NUM_MAX = 64'sd2147483647;
    localparam longint NUM_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [NUM_W-1:0] top_value;
        logic             done_res;
    } token_result_t;

    logic signed [NUM_W-1:0] stack_mem [RPN_STACK_DEPTH];
    int unsigned             depth;
    logic [ST_W-1:0]         err_latch;
    token_result_t           expected_q [$];
    int                      fails;

    // Evaluate one token against the shadow stack.
    function automatic token_result_t apply_token(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [NUM_W-1:0] num);
        token_result_t res;
        longint        a;
        longint        b;
        longint        r;
        res = '0;
        if (cmd == CMD_END) begin
            res.done_res = 1'b1;
            if (err_latch != ST_OK) begin
                res.status = err_latch;
            end else if (depth == 0) begin
                res.status = ST_TOOFEW;
            end else if (depth > 1) begin
                res.status = ST_TOOMANY;
            end else begin
                res.status    = ST_OK;
                res.top_value = stack_mem[0];
            end
            depth     = 0;
            err_latch = ST_OK;
            return res;
        end
        if (err_latch == ST_OK) begin
            case (cmd)
                CMD_PUSH: begin
                    if (depth >= RPN_STACK_DEPTH) begin
                        err_latch = ST_OVERFLOW;
                    end else begin
                        stack_mem[depth] = num;
                        depth++;
                    end
                end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                    if (depth < 2) begin
                        err_latch = ST_UNDERFLOW;
                    end else begin
                        a = stack_mem[depth-2];
                        b = stack_mem[depth-1];
                        if (cmd == CMD_DIV && b == 0) begin
                            err_latch = ST_DIVZERO;
                        end else begin
                            case (cmd)
                                CMD_ADD: r = a + b;
                                CMD_SUB: r = a - b;
                                // arithmetic shift floors toward minus infinity
                                CMD_MUL: r = (a * b) >>> RPN_FRACTION_BITS;
                                // signed divide truncates toward zero
                                default: r = (a <<< RPN_FRACTION_BITS) / b;
                            endcase
                            if (r > NUM_MAX) r = NUM_MAX;
                            else if (r < NUM_MIN) r = NUM_MIN;
                            depth--;
                            stack_mem[depth-1] = r[NUM_W-1:0];
                        end
                    end
                end
                default: err_latch = ST_INVALID;
            endcase
        end
        res.status    = err_latch;
        res.top_value = (depth == 0) ? '0 : stack_mem[depth-1];
        return res;
    endfunction

    initial begin
        fails      = 0;
        fail_count = 0;
        pending    = 0;
        depth      = 0;
        err_latch  = ST_OK;
    end

    always @(posedge aclk) begin : monitor
        token_result_t got;
        token_result_t want;
        if (!aresetn) begin
            depth     = 0;
            err_latch = ST_OK;
            expected_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_token(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                got = {m_tdata[2:0], m_tdata[34:3], m_tlast};
                if (expected_q.size() == 0) begin
                    $error("unexpected item: status %0d top_value %0d done_res %0d",
                           got.status, $signed(got.top_value), got.done_res);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        fails++;
                    end
                    if (got.top_value !== want.top_value) begin
                        $error("top_value: expected %0d, actual %0d",
                               $signed(want.top_value), $signed(got.top_value));
                        fails++;
                    end
                    if (got.done_res !== want.done_res) begin
                        $error("done_res: expected %0d, actual %0d",
                               want.done_res, got.done_res);
                        fails++;
                    end
                end
            end
        end
        fail_count <= fails;
        pending    <= expected_q.size();
    end

endmodule

@@ tb/sv/tb_rpn_stack_evaluator.sv @@
// Testbench top for the RPN evaluator: clock, reset, token stimulus and the verdict.
`timescale 1ns / 1ps

module tb_rpn_stack_evaluator;
    import rpn_pkg::*;

    localparam logic [CMD_W-1:0] CMD_BAD_LO  = 3'd6;
    localparam logic [CMD_W-1:0] CMD_BAD_HI  = 3'd7;
    localparam int               TOKEN_GOAL  = 1950;
    localparam int               CYCLE_LIMIT = 1000000;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [NUM_W-1:0] s_tdata;
    logic [CMD_W-1:0] s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [39:0]      m_tdata;
    logic             m_tlast;

    int   fail_count;
    int   pending;
    int   cycles;
    int   tokens_sent;
    logic steady;

    rpn_stack_evaluator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    rpn_result_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 34);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_token(input logic [CMD_W-1:0] cmd, input logic [NUM_W-1:0] num);
        while (!steady && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= num;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tokens_sent++;
    endtask

    // Mostly Q16.16 values of modest size, with zeros and extremes mixed in.
    function automatic logic [NUM_W-1:0] rand_number();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return $urandom;
            4, 5, 6: return ($urandom_range(0, 200) - 100) << RPN_FRACTION_BITS;
            default: return ($urandom & 32'h007F_FFFF) - 32'h0040_0000;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] rand_arith();
        case ($urandom_range(0, 3))
            0:       return CMD_ADD;
            1:       return CMD_SUB;
            2:       return CMD_MUL;
            default: return CMD_DIV;
        endcase
    endfunction

    // Valid RPN expression, sometimes broken at the end or too deep for the stack.
    task automatic send_expression();
        int n_push;
        int pushed;
        int level;
        int pick;
        bit deep_first;
        pushed = 0;
        level  = 0;
        pick   = $urandom_range(0, 99);
        if (pick < 85)      n_push = $urandom_range(1, 6);
        else if (pick < 95) n_push = $urandom_range(7, RPN_STACK_DEPTH);
        else                n_push = $urandom_range(RPN_STACK_DEPTH + 1, RPN_STACK_DEPTH + 2);
        deep_first = (n_push > RPN_STACK_DEPTH) || ($urandom_range(0, 3) == 0);
        while (pushed < n_push || level > 1) begin
            if (pushed < n_push && (level < 2 || deep_first || $urandom_range(0, 1))) begin
                send_token(CMD_PUSH, rand_number());
                pushed++;
                level++;
            end else begin
                send_token(rand_arith(), rand_number());
                level--;
            end
        end
        case ($urandom_range(0, 9))
            0: send_token(rand_arith(), $urandom);
            1: send_token(CMD_PUSH, rand_number());
            default: ;
        endcase
        send_token(CMD_END, $urandom);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) send_token(CMD_W'($urandom_range(0, 7)), $urandom);
        if ($urandom_range(0, 9) < 7) send_token(CMD_END, $urandom);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = CMD_PUSH;
        s_tdata     = '0;
        m_tready    = 1'b0;
        steady      = 1'b0;
        cycles      = 0;
        tokens_sent = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // end on an empty stack
        send_token(CMD_END, 32'hFFFF_FFFF);
        // saturating add, subtract, multiply and divide
        send_token(CMD_PUSH, 32'h7FFF_FFFF);
        send_token(CMD_PUSH, 32'h7FFF_FFFF);
        send_token(CMD_ADD, '0);
        send_token(CMD_PUSH, 32'h8000_0000);
        send_token(CMD_SUB, '0);
        send_token(CMD_PUSH, 32'h8000_0000);
        send_token(CMD_MUL, '0);
        send_token(CMD_PUSH, 32'h0000_0001);
        send_token(CMD_DIV, '0);
        // divide by zero, then a push that must be ignored
        send_token(CMD_PUSH, '0);
        send_token(CMD_DIV, '0);
        send_token(CMD_PUSH, 32'h0005_0000);
        send_token(CMD_END, '0);
        // operation on an empty stack
        send_token(CMD_ADD, '0);
        send_token(CMD_END, '0);
        // two entries left at end
        send_token(CMD_PUSH, 32'h0003_0000);
        send_token(CMD_PUSH, 32'h0003_0000);
        send_token(CMD_END, '0);
        // both invalid token codes
        send_token(CMD_BAD_LO, 32'hA5A5_5A5A);
        send_token(CMD_END, '0);
        send_token(CMD_BAD_HI, 32'h5A5A_A5A5);
        send_token(CMD_END, '0);
        // clean divide: -2.0 / 1.5
        send_token(CMD_PUSH, 32'hFFFE_0000);
        send_token(CMD_PUSH, 32'h0001_8000);
        send_token(CMD_DIV, '0);
        send_token(CMD_END, '0);

        while (tokens_sent < TOKEN_GOAL) begin
            // a stretch with no idling on either side
            steady <= (tokens_sent >= 900 && tokens_sent < 1200);
            if ($urandom_range(0, 9) < 8) send_expression();
            else send_noise();
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
